// ===== sv/i2cht_pkg.sv =====
package i2cht_pkg;

    // Bus event codes carried in the operation field.
    localparam logic [2:0] OP_START_WRITE = 3'd0;
    localparam logic [2:0] OP_START_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE_BYTE  = 3'd2;
    localparam logic [2:0] OP_READ_BYTE   = 3'd3;
    localparam logic [2:0] OP_STOP        = 3'd4;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd112;

    // Sixteen-bit command words.
    localparam logic [15:0] CMD_WORD_WAKE       = 16'h3517;
    localparam logic [15:0] CMD_WORD_SLEEP      = 16'hB098;
    localparam logic [15:0] CMD_WORD_MEAS_T_A   = 16'h7866;
    localparam logic [15:0] CMD_WORD_MEAS_T_B   = 16'h7CA2;
    localparam logic [15:0] CMD_WORD_MEAS_H_A   = 16'h609C;
    localparam logic [15:0] CMD_WORD_MEAS_H_B   = 16'h6458;
    localparam logic [15:0] CMD_WORD_READ_ID    = 16'hEFC8;
    localparam logic [15:0] CMD_WORD_SOFT_RESET = 16'h805D;

    localparam logic [15:0] ID_WORD  = 16'h0807;
    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;

    localparam int RESP_DEPTH = 6;
    localparam int RESP_IDX_W = $clog2(RESP_DEPTH);

    // Temperature: code = floor((v * 32768 + 4375) / 8750) for v = T + 4500 below 17500.
    localparam int          TEMP_OFFSET  = 4500;
    localparam int          TEMP_LIMIT   = 17500;
    localparam int          TEMP_DIV     = 8750;
    localparam int          TEMP_BIAS    = 4375;
    localparam int          TEMP_SHIFT   = 44;
    localparam logic [30:0] TEMP_RECIP   =
        31'(((64'd1 << TEMP_SHIFT) + 64'(TEMP_DIV) - 64'd1) / 64'(TEMP_DIV));

    // Humidity: code = floor((H * 8192 + 625) / 1250) for H below 10000.
    localparam int          HUM_LIMIT    = 10000;
    localparam int          HUM_DIV      = 1250;
    localparam int          HUM_BIAS     = 625;
    localparam int          HUM_SHIFT    = 38;
    localparam logic [27:0] HUM_RECIP    =
        28'(((64'd1 << HUM_SHIFT) + 64'(HUM_DIV) - 64'd1) / 64'(HUM_DIV));

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_START_WRITE,
        KIND_START_READ,
        KIND_CMD_FIRST,
        KIND_CMD,
        KIND_READ,
        KIND_NONE
    } item_kind_t;

    typedef enum logic [2:0] {
        CMD_WAKE,
        CMD_SLEEP,
        CMD_MEAS_T,
        CMD_MEAS_H,
        CMD_READ_ID,
        CMD_SOFT_RESET,
        CMD_OTHER
    } cmd_t;

    typedef struct packed {
        item_kind_t  kind;
        logic        addr_match;
        cmd_t        cmd;
        logic [15:0] temp_code;
        logic [15:0] hum_code;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

    // CRC-8 over a word, high byte first, MSB first, no final inversion.
    function automatic logic [7:0] crc8_word(input logic [15:0] word);
        logic [7:0] crc;
        logic       fb;
        crc = CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            fb  = crc[7] ^ word[i];
            crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    localparam logic [7:0] ID_CRC = crc8_word(ID_WORD);

endpackage

// ===== sv/i2cht_if.sv =====
interface i2cht_request_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [6:0]         bus_address;
    logic [7:0]         write_data;
    logic signed [15:0] temperature_centi;
    logic signed [14:0] humidity_centi;

    modport source (
        output valid, operation, bus_address, write_data, temperature_centi,
               humidity_centi,
        input  ready
    );
    modport sink (
        input  valid, operation, bus_address, write_data, temperature_centi,
               humidity_centi,
        output ready
    );
endinterface

interface i2cht_response_if;
    logic       valid;
    logic       ready;
    logic       ack;
    logic [7:0] read_data;

    modport source (output valid, ack, read_data, input ready);
    modport sink (input valid, ack, read_data, output ready);
endinterface

interface i2cht_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] device_address;

    modport source (output valid, device_address, input ready);
    modport sink (input valid, device_address, output ready);
endinterface

// ===== sv/i2cht_front.sv =====
module i2cht_front (
    input  logic                  clk,
    input  logic                  rst_n,
    i2cht_request_if.sink         request,
    i2cht_cfg_if.sink             cfg,
    input  logic                  queue_full,
    output i2cht_pkg::push_t      push
);

    logic [6:0] device_address_reg;
    logic [7:0] first_byte_reg;
    logic [7:0] first_byte_next;
    logic       byte_count_reg;
    logic       byte_count_next;
    logic       accept;

    logic signed [16:0] t_sum;
    logic [29:0]        t_num;
    logic [60:0]        t_prod;
    logic [26:0]        h_num;
    logic [54:0]        h_prod;
    logic [15:0]        temp_code;
    logic [15:0]        hum_code;
    logic [15:0]        cmd_word;

    i2cht_pkg::item_t item;
    i2cht_pkg::cmd_t  cmd;

    assign cfg.ready     = 1'b1;
    assign request.ready = !queue_full;
    assign accept        = request.valid && !queue_full;

    // Rounded conversions, done by multiplying with a scaled reciprocal.
    always_comb
    begin
        t_sum  = 17'(request.temperature_centi) + 17'(i2cht_pkg::TEMP_OFFSET);
        t_num  = {t_sum[14:0], 15'd0} + 30'(i2cht_pkg::TEMP_BIAS);
        t_prod = 61'(t_num) * 61'(i2cht_pkg::TEMP_RECIP);
        if (t_sum[16])
        begin
            temp_code = 16'h0000;
        end
        else if (t_sum >= 17'(i2cht_pkg::TEMP_LIMIT))
        begin
            temp_code = 16'hFFFF;
        end
        else
        begin
            temp_code = t_prod[i2cht_pkg::TEMP_SHIFT + 15 : i2cht_pkg::TEMP_SHIFT];
        end

        h_num  = {request.humidity_centi[13:0], 13'd0} + 27'(i2cht_pkg::HUM_BIAS);
        h_prod = 55'(h_num) * 55'(i2cht_pkg::HUM_RECIP);
        if (request.humidity_centi[14])
        begin
            hum_code = 16'h0000;
        end
        else if (request.humidity_centi >= 15'(i2cht_pkg::HUM_LIMIT))
        begin
            hum_code = 16'hFFFF;
        end
        else
        begin
            hum_code = h_prod[i2cht_pkg::HUM_SHIFT + 15 : i2cht_pkg::HUM_SHIFT];
        end
    end

    assign cmd_word = {first_byte_reg, request.write_data};

    always_comb
    begin
        case (cmd_word)
            i2cht_pkg::CMD_WORD_WAKE:       cmd = i2cht_pkg::CMD_WAKE;
            i2cht_pkg::CMD_WORD_SLEEP:      cmd = i2cht_pkg::CMD_SLEEP;
            i2cht_pkg::CMD_WORD_MEAS_T_A,
            i2cht_pkg::CMD_WORD_MEAS_T_B:   cmd = i2cht_pkg::CMD_MEAS_T;
            i2cht_pkg::CMD_WORD_MEAS_H_A,
            i2cht_pkg::CMD_WORD_MEAS_H_B:   cmd = i2cht_pkg::CMD_MEAS_H;
            i2cht_pkg::CMD_WORD_READ_ID:    cmd = i2cht_pkg::CMD_READ_ID;
            i2cht_pkg::CMD_WORD_SOFT_RESET: cmd = i2cht_pkg::CMD_SOFT_RESET;
            default:                        cmd = i2cht_pkg::CMD_OTHER;
        endcase
    end

    // Classify the event and track command byte pairing.
    always_comb
    begin
        first_byte_next = first_byte_reg;
        byte_count_next = byte_count_reg;
        item.addr_match = (request.bus_address == device_address_reg);
        item.cmd        = cmd;
        item.temp_code  = temp_code;
        item.hum_code   = hum_code;
        case (request.operation)
            i2cht_pkg::OP_START_WRITE:
            begin
                item.kind = i2cht_pkg::KIND_START_WRITE;
                if (item.addr_match)
                begin
                    byte_count_next = 1'b0;
                end
            end
            i2cht_pkg::OP_START_READ:
            begin
                item.kind = i2cht_pkg::KIND_START_READ;
            end
            i2cht_pkg::OP_WRITE_BYTE:
            begin
                if (!byte_count_reg)
                begin
                    item.kind       = i2cht_pkg::KIND_CMD_FIRST;
                    first_byte_next = request.write_data;
                    byte_count_next = 1'b1;
                end
                else
                begin
                    item.kind       = i2cht_pkg::KIND_CMD;
                    byte_count_next = 1'b0;
                end
            end
            i2cht_pkg::OP_READ_BYTE:
            begin
                item.kind = i2cht_pkg::KIND_READ;
            end
            i2cht_pkg::OP_STOP:
            begin
                item.kind       = i2cht_pkg::KIND_NONE;
                byte_count_next = 1'b0;
            end
            default:
            begin
                item.kind = i2cht_pkg::KIND_NONE;
            end
        endcase
    end

    assign push.push = accept;
    assign push.item = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= i2cht_pkg::DEVICE_ADDRESS_RESET;
            first_byte_reg     <= 8'h00;
            byte_count_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                device_address_reg <= cfg.device_address;
            end
            if (accept)
            begin
                first_byte_reg <= first_byte_next;
                byte_count_reg <= byte_count_next;
            end
        end
    end

endmodule

// ===== sv/i2cht_queue.sv =====
module i2cht_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cht_pkg::push_t      push,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output i2cht_pkg::item_t      head
);

    localparam logic [i2cht_pkg::QUEUE_CNT_W-1:0] DEPTH_COUNT =
        i2cht_pkg::QUEUE_CNT_W'(i2cht_pkg::QUEUE_DEPTH);

    i2cht_pkg::item_t                   entry_reg [i2cht_pkg::QUEUE_DEPTH];
    logic [i2cht_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [i2cht_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [i2cht_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [i2cht_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full    = (count_reg == DEPTH_COUNT);
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push.push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ===== sv/i2cht_back.sv =====
module i2cht_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  queue_empty,
    input  i2cht_pkg::item_t      head,
    output logic                  pop,
    i2cht_response_if.source      response
);

    localparam logic [2:0] RESP_FULL_LEN = 3'(i2cht_pkg::RESP_DEPTH);
    localparam logic [2:0] RESP_ID_LEN   = 3'd3;

    logic       sleeping_reg;
    logic       sleeping_next;
    logic [2:0] resp_len_reg;
    logic [2:0] resp_len_next;
    logic [2:0] resp_pos_reg;
    logic [2:0] resp_pos_next;
    logic [7:0] resp_bytes_reg  [i2cht_pkg::RESP_DEPTH];
    logic [7:0] resp_bytes_next [i2cht_pkg::RESP_DEPTH];
    logic       out_valid_reg;
    logic       ack_reg;
    logic       ack_next;
    logic [7:0] read_data_reg;
    logic [7:0] read_data_next;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [7:0]  crc0;
    logic [7:0]  crc1;
    logic [i2cht_pkg::RESP_IDX_W-1:0] rd_idx;

    assign pop = !queue_empty && (!out_valid_reg || response.ready);

    assign response.valid     = out_valid_reg;
    assign response.ack       = ack_reg;
    assign response.read_data = read_data_reg;

    assign word0  = (head.cmd == i2cht_pkg::CMD_MEAS_H) ? head.hum_code : head.temp_code;
    assign word1  = (head.cmd == i2cht_pkg::CMD_MEAS_H) ? head.temp_code : head.hum_code;
    assign crc0   = i2cht_pkg::crc8_word(word0);
    assign crc1   = i2cht_pkg::crc8_word(word1);
    assign rd_idx = resp_pos_reg[i2cht_pkg::RESP_IDX_W-1:0];

    always_comb
    begin
        sleeping_next   = sleeping_reg;
        resp_len_next   = resp_len_reg;
        resp_pos_next   = resp_pos_reg;
        resp_bytes_next = resp_bytes_reg;
        ack_next        = 1'b0;
        read_data_next  = 8'h00;
        case (head.kind)
            i2cht_pkg::KIND_START_WRITE:
            begin
                ack_next = head.addr_match;
            end
            i2cht_pkg::KIND_START_READ:
            begin
                ack_next = head.addr_match && !sleeping_reg;
            end
            i2cht_pkg::KIND_CMD_FIRST:
            begin
                ack_next = 1'b1;
            end
            i2cht_pkg::KIND_CMD:
            begin
                if (head.cmd == i2cht_pkg::CMD_WAKE)
                begin
                    sleeping_next = 1'b0;
                    ack_next      = 1'b1;
                end
                else if (!sleeping_reg)
                begin
                    ack_next = 1'b1;
                    case (head.cmd)
                        i2cht_pkg::CMD_SLEEP:
                        begin
                            sleeping_next = 1'b1;
                        end
                        i2cht_pkg::CMD_MEAS_T,
                        i2cht_pkg::CMD_MEAS_H:
                        begin
                            resp_bytes_next[0] = word0[15:8];
                            resp_bytes_next[1] = word0[7:0];
                            resp_bytes_next[2] = crc0;
                            resp_bytes_next[3] = word1[15:8];
                            resp_bytes_next[4] = word1[7:0];
                            resp_bytes_next[5] = crc1;
                            resp_len_next      = RESP_FULL_LEN;
                            resp_pos_next      = 3'd0;
                        end
                        i2cht_pkg::CMD_READ_ID:
                        begin
                            resp_bytes_next[0] = i2cht_pkg::ID_WORD[15:8];
                            resp_bytes_next[1] = i2cht_pkg::ID_WORD[7:0];
                            resp_bytes_next[2] = i2cht_pkg::ID_CRC;
                            resp_len_next      = RESP_ID_LEN;
                            resp_pos_next      = 3'd0;
                        end
                        i2cht_pkg::CMD_SOFT_RESET:
                        begin
                            sleeping_next = 1'b0;
                            resp_len_next = 3'd0;
                            resp_pos_next = 3'd0;
                        end
                        default:
                        begin
                            // An unknown command drops any buffered response bytes.
                            resp_len_next = 3'd0;
                            resp_pos_next = 3'd0;
                        end
                    endcase
                end
            end
            i2cht_pkg::KIND_READ:
            begin
                if (resp_pos_reg < resp_len_reg && resp_pos_reg < RESP_FULL_LEN)
                begin
                    read_data_next = resp_bytes_reg[rd_idx];
                    resp_pos_next  = resp_pos_reg + 3'd1;
                end
                else
                begin
                    read_data_next = 8'hFF;
                end
            end
            default:
            begin
                ack_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleeping_reg  <= 1'b0;
            resp_len_reg  <= 3'd0;
            resp_pos_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                sleeping_reg  <= sleeping_next;
                resp_len_reg  <= resp_len_next;
                resp_pos_reg  <= resp_pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            resp_bytes_reg <= resp_bytes_next;
            ack_reg        <= ack_next;
            read_data_reg  <= read_data_next;
        end
    end

endmodule

// ===== sv/i2c_humidity_sensor_target.sv =====
// Channel    Role    Payload
// request    sink    operation, bus_address, write_data, temperature_centi, humidity_centi
// response   source  ack, read_data
// cfg        sink    device_address (always ready)
//
// One item per cycle unless the queue is full; results are queued, then registered out.
// The front classifies events and does the conversions, a four-entry queue feeds
// the back, which owns the sleep flag and the response buffer.
// Reset is asynchronous: address 112, awake, nothing queued.
// When response stalls, up to four items wait in the queue before request.ready drops.
module i2c_humidity_sensor_target (
    input  logic              clk,
    input  logic              rst_n,
    i2cht_request_if.sink     request,
    i2cht_response_if.source  response,
    i2cht_cfg_if.sink         cfg
);

    i2cht_pkg::push_t push;
    i2cht_pkg::item_t head;
    logic             queue_full;
    logic             queue_empty;
    logic             pop;

    i2cht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push)
    );

    i2cht_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .empty (queue_empty),
        .head  (head)
    );

    i2cht_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .response    (response)
    );

endmodule

// ===== sim/i2cht_reply_checker.sv =====
`timescale 1ns / 100ps

module i2cht_reply_checker
    import i2cht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cht_request_if    request,
    i2cht_response_if   response,
    i2cht_cfg_if        cfg,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic       ack;
        logic [7:0] read_data;
    } reply_t;

    reply_t     expected_replies[$];

    // Own copy of the sensor state.
    logic [6:0] own_address;
    logic [7:0] cmd_high;
    logic       cmd_half;
    logic [7:0] reply_bytes [6];
    logic [2:0] reply_len;
    logic [2:0] reply_pos;
    logic       asleep;

    function automatic logic [7:0] crc_of_word(input logic [15:0] word);
        logic [7:0] c;
        c = 8'hFF;
        for (int n = 0; n < 2; n++) begin
            c ^= (n == 0) ? word[15:8] : word[7:0];
            for (int b = 0; b < 8; b++)
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Rounds num * 65536 / den half up, clamped to sixteen bits.
    function automatic logic [15:0] scaled_code(input longint num, input longint den);
        longint q;
        if (num < 0)
            return 16'd0;
        q = (num * 131072 + den) / (2 * den);
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic void load_word(input int slot, input logic [15:0] word);
        reply_bytes[slot]     = word[15:8];
        reply_bytes[slot + 1] = word[7:0];
        reply_bytes[slot + 2] = crc_of_word(word);
    endfunction

    function automatic void load_measurement(input logic hum_first,
                                             input logic signed [15:0] temp,
                                             input logic signed [14:0] hum);
        logic [15:0] temp_code;
        logic [15:0] hum_code;
        temp_code = scaled_code(longint'(temp) + 4500, 17500);
        hum_code  = scaled_code(longint'(hum), 10000);
        load_word(0, hum_first ? hum_code : temp_code);
        load_word(3, hum_first ? temp_code : hum_code);
        reply_len = 3'd6;
        reply_pos = 3'd0;
    endfunction

    function automatic logic run_command(input logic [15:0] cmd,
                                         input logic signed [15:0] temp,
                                         input logic signed [14:0] hum);
        if (cmd == CMD_WORD_WAKE) begin
            asleep = 1'b0;
            return 1'b1;
        end
        if (asleep)
            return 1'b0;
        case (cmd)
            CMD_WORD_SLEEP:
                asleep = 1'b1;
            CMD_WORD_MEAS_T_A, CMD_WORD_MEAS_T_B:
                load_measurement(1'b0, temp, hum);
            CMD_WORD_MEAS_H_A, CMD_WORD_MEAS_H_B:
                load_measurement(1'b1, temp, hum);
            CMD_WORD_READ_ID:
            begin
                load_word(0, ID_WORD);
                reply_len = 3'd3;
                reply_pos = 3'd0;
            end
            CMD_WORD_SOFT_RESET:
            begin
                asleep    = 1'b0;
                reply_len = 3'd0;
                reply_pos = 3'd0;
            end
            default:
            begin
                reply_len = 3'd0;
                reply_pos = 3'd0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic reply_t predict_reply(input logic [2:0] op, input logic [6:0] addr,
                                             input logic [7:0] data,
                                             input logic signed [15:0] temp,
                                             input logic signed [14:0] hum);
        reply_t r;
        r = '0;
        case (op)
            OP_START_WRITE:
                if (addr == own_address) begin
                    r.ack    = 1'b1;
                    cmd_half = 1'b0;
                end
            OP_START_READ:
                r.ack = (addr == own_address) && !asleep;
            OP_WRITE_BYTE:
                if (!cmd_half) begin
                    cmd_high = data;
                    cmd_half = 1'b1;
                    r.ack    = 1'b1;
                end else begin
                    cmd_half = 1'b0;
                    r.ack    = run_command({cmd_high, data}, temp, hum);
                end
            OP_READ_BYTE:
                if (reply_pos < reply_len) begin
                    r.read_data = reply_bytes[reply_pos];
                    reply_pos   = reply_pos + 3'd1;
                end else begin
                    r.read_data = 8'hFF;
                end
            OP_STOP:
                cmd_half = 1'b0;
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        reply_t want;
        if (!rst_n) begin
            own_address = DEVICE_ADDRESS_RESET;
            cmd_high    = 8'd0;
            cmd_half    = 1'b0;
            reply_len   = 3'd0;
            reply_pos   = 3'd0;
            asleep      = 1'b0;
            expected_replies.delete();
        end else begin
            if (cfg.valid && cfg.ready)
                own_address = cfg.device_address;
            if (response.valid && response.ready) begin
                if (expected_replies.size() == 0) begin
                    flag_error($sformatf("unexpected result: ack %0b read_data %02h",
                                         response.ack, response.read_data));
                end else begin
                    want = expected_replies.pop_front();
                    if (response.ack !== want.ack || response.read_data !== want.read_data)
                        flag_error($sformatf({"result mismatch: ack %0b read_data %02h, ",
                                              "expected ack %0b read_data %02h"},
                                             response.ack, response.read_data,
                                             want.ack, want.read_data));
                end
            end
            if (request.valid && request.ready)
                expected_replies.push_back(predict_reply(request.operation,
                                                         request.bus_address,
                                                         request.write_data,
                                                         request.temperature_centi,
                                                         request.humidity_centi));
        end
        pending = expected_replies.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import i2cht_pkg::*;

    logic       clk;
    logic       rst_n;
    int         errors;
    int         pending;
    int         items_sent;
    int         hold_after;
    bit         steady;
    bit         hold_request;
    logic [6:0] target_address;

    i2cht_request_if  request();
    i2cht_response_if response();
    i2cht_cfg_if      cfg();

    i2c_humidity_sensor_target dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cfg      (cfg)
    );

    i2cht_reply_checker reply_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cfg      (cfg),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Result side: random stalls, or one long hold-off when asked for.
    initial begin
        response.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                response.ready <= 1'b0;
                repeat (80) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                response.ready <= steady || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    function automatic logic signed [15:0] rand_temp();
        int v;
        v = $urandom_range(0, 30000);
        case ($urandom_range(0, 15))
            0: return -16'sd10000;
            1: return 16'sd20000;
            2: return -16'sd4501;
            3: return -16'sd4500;
            4: return 16'sd13000;
            default: return 16'(v - 10000);
        endcase
    endfunction

    function automatic logic signed [14:0] rand_hum();
        int v;
        v = $urandom_range(0, 14000);
        case ($urandom_range(0, 15))
            0: return -15'sd2000;
            1: return 15'sd12000;
            2: return -15'sd1;
            3: return 15'sd0;
            4: return 15'sd10000;
            default: return 15'(v - 2000);
        endcase
    endfunction

    function automatic logic [15:0] pick_command();
        case ($urandom_range(0, 19))
            0, 1, 2: return CMD_WORD_MEAS_T_A;
            3, 4:    return CMD_WORD_MEAS_T_B;
            5, 6, 7: return CMD_WORD_MEAS_H_A;
            8, 9:    return CMD_WORD_MEAS_H_B;
            10, 11:  return CMD_WORD_READ_ID;
            12:      return CMD_WORD_SLEEP;
            13, 14:  return CMD_WORD_WAKE;
            15:      return CMD_WORD_SOFT_RESET;
            16:      return {CMD_WORD_MEAS_T_A[15:8], 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // Called and returning at a falling edge.
    task automatic send_item(input logic [2:0] op, input logic [6:0] addr,
                             input logic [7:0] data, input logic signed [15:0] temp,
                             input logic signed [14:0] hum);
        if (!steady && $urandom_range(0, 99) < 25) begin
            request.valid <= 1'b0;
            @(negedge clk);
        end
        request.valid             <= 1'b1;
        request.operation         <= op;
        request.bus_address       <= addr;
        request.write_data        <= data;
        request.temperature_centi <= temp;
        request.humidity_centi    <= hum;
        do @(posedge clk); while (!request.ready);
        if (op <= OP_STOP)
            items_sent++;
        if (items_sent == hold_after)
            hold_request = 1'b1;
        @(negedge clk);
    endtask

    task automatic send_event(input logic [2:0] op, input logic [6:0] addr,
                              input logic [7:0] data);
        send_item(op, addr, data, rand_temp(), rand_hum());
    endtask

    task automatic drain_replies();
        request.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_address(input logic [6:0] value);
        cfg.valid          <= 1'b1;
        cfg.device_address <= value;
        do @(posedge clk); while (!cfg.ready);
        target_address = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Mostly well-formed command and read sequences, with some noise mixed in.
    task automatic run_transaction();
        logic [15:0] cmd;
        logic [6:0]  addr;
        int          pick;
        pick = $urandom_range(0, 99);
        addr = ($urandom_range(0, 9) == 0) ? 7'($urandom) : target_address;
        if (pick < 12) begin
            send_event(($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4)),
                       7'($urandom), 8'($urandom));
        end else begin
            cmd = pick_command();
            send_event(OP_START_WRITE, addr, 8'($urandom));
            send_event(OP_WRITE_BYTE, 7'($urandom), cmd[15:8]);
            if (pick < 16)
                send_event(OP_STOP, 7'($urandom), 8'($urandom));
            send_event(OP_WRITE_BYTE, 7'($urandom), cmd[7:0]);
            send_event(OP_STOP, 7'($urandom), 8'($urandom));
            if ($urandom_range(0, 3) != 0) begin
                send_event(OP_START_READ, addr, 8'($urandom));
                repeat ($urandom_range(0, 8))
                    send_event(OP_READ_BYTE, 7'($urandom), 8'($urandom));
                send_event(OP_STOP, 7'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        int         goal;
        logic [6:0] next_address;
        rst_n                     = 1'b0;
        request.valid             = 1'b0;
        request.operation         = OP_STOP;
        request.bus_address       = 7'd0;
        request.write_data        = 8'd0;
        request.temperature_centi = 16'sd0;
        request.humidity_centi    = 15'sd0;
        cfg.valid                 = 1'b0;
        cfg.device_address        = 7'd0;
        items_sent                = 0;
        hold_after                = -1;
        steady                    = 1'b0;
        hold_request              = 1'b0;
        target_address            = DEVICE_ADDRESS_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Measure at the low extremes, where both codes clamp to zero.
        send_event(OP_START_WRITE, DEVICE_ADDRESS_RESET, 8'h00);
        send_event(OP_WRITE_BYTE, 7'h7F, CMD_WORD_MEAS_T_A[15:8]);
        send_item(OP_WRITE_BYTE, 7'h00, CMD_WORD_MEAS_T_A[7:0], -16'sd10000, -15'sd2000);
        send_event(OP_START_READ, 7'd0, 8'hFF);
        repeat (7) send_event(OP_READ_BYTE, 7'($urandom), 8'($urandom));
        // High extremes clamp to full scale; read only part of the result.
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_MEAS_H_A[15:8]);
        send_item(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_MEAS_H_A[7:0], 16'sd20000,
                  15'sd12000);
        send_event(OP_READ_BYTE, 7'($urandom), 8'($urandom));
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_READ_ID[15:8]);
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_READ_ID[7:0]);
        // Asleep: reads are refused, commands other than wake have no effect,
        // and read bytes still drain what was queued.
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_SLEEP[15:8]);
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_SLEEP[7:0]);
        send_event(OP_START_READ, DEVICE_ADDRESS_RESET, 8'($urandom));
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_SOFT_RESET[15:8]);
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_SOFT_RESET[7:0]);
        send_event(OP_READ_BYTE, 7'($urandom), 8'($urandom));
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_WAKE[15:8]);
        send_event(OP_WRITE_BYTE, 7'($urandom), CMD_WORD_WAKE[7:0]);
        // An unknown command clears the response buffer.
        send_event(OP_WRITE_BYTE, 7'($urandom), 8'h12);
        send_event(OP_WRITE_BYTE, 7'($urandom), 8'h34);
        send_event(OP_READ_BYTE, 7'($urandom), 8'($urandom));
        send_event(3'd7, 7'h7F, 8'hFF);
        send_event(OP_STOP, 7'($urandom), 8'($urandom));
        send_event(OP_START_WRITE, 7'h7F, 8'($urandom));

        for (int phase = 0; phase < 5; phase++) begin
            drain_replies();
            case (phase)
                0:       next_address = 7'd0;
                1:       next_address = 7'd127;
                3:       next_address = DEVICE_ADDRESS_RESET;
                default: next_address = 7'($urandom);
            endcase
            write_address(next_address);
            steady     = (phase == 2);
            hold_after = (phase == 1 || phase == 3) ? items_sent + 60 : -1;
            goal       = items_sent + 210;
            while (items_sent < goal)
                run_transaction();
        end

        drain_replies();
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
